// ===== design/m3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types, widths and command codes for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
`default_nettype none
package m3inv_pkg;
   localparam int DIM         = 3;
   localparam int NCELLS      = DIM * DIM;
   localparam int ELEM_W      = 16;
   localparam int OUT_W       = 32;
   localparam int IDX_W       = 4;
   localparam int PROD_W      = 32;
   localparam int COF_W       = 34;
   localparam int DET_W       = 51;
   localparam int NUM_W       = COF_W + 24;
   localparam int QSTEP_W     = 6;
   localparam int DIV_STEPS   = NUM_W;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_COF,
      ST_DET,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             load;
      logic             cof_step;
      logic             det_step;
      logic             div_start;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic det_zero;
   } status_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] inverse_entry;
      logic                    singular;
      logic                    saturated;
      logic                    last;
   } rsp_type;

   // Row/column indexes here never exceed 2*DIM-2, so one wrap is enough.
   function automatic logic [IDX_W-1:0] cyc(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
      logic [IDX_W-1:0] rw, cw;
      rw  = (r >= IDX_W'(DIM)) ? r - IDX_W'(DIM) : r;
      cw  = (c >= IDX_W'(DIM)) ? c - IDX_W'(DIM) : c;
      cyc = rw * IDX_W'(DIM) + cw;
   endfunction
endpackage
`default_nettype wire

// ===== design/m3inv_stream_if.sv =====
// ----------------------------------------------------------------------------
// m3inv_stream_if
// Valid/ready channel carrying a payload of parameter width.
// ----------------------------------------------------------------------------
`default_nettype none
interface m3inv_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/m3inv_datapath.sv =====
// ----------------------------------------------------------------------------
// m3inv_datapath
// Matrix store, multipliers, cofactor/determinant accumulation,
// restoring divider and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module m3inv_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire m3inv_pkg::cmd_type                   cmd,
   input  wire logic signed [m3inv_pkg::ELEM_W-1:0]  element,
   output m3inv_pkg::status_type                     status,
   output logic signed [m3inv_pkg::OUT_W-1:0]        quotient,
   output logic                                      sat
);
   logic signed [m3inv_pkg::ELEM_W-1:0] mat_ff [m3inv_pkg::NCELLS];
   logic signed [m3inv_pkg::COF_W-1:0]  cof_ff [m3inv_pkg::NCELLS];
   logic signed [m3inv_pkg::DET_W-1:0]  det_ff, det_in;
   logic signed [m3inv_pkg::PROD_W-1:0] pa_ff, pb_ff;
   logic [1:0]                          cph_ff;
   logic [m3inv_pkg::IDX_W-1:0]         r, c, r1, r2, c1, c2;

   // Divider state
   logic [m3inv_pkg::NUM_W-1:0]  rem_ff, quo_ff, num_mag;
   logic [m3inv_pkg::DET_W-1:0]  dmag_ff;
   logic                         neg_ff, busy_ff;
   logic [m3inv_pkg::QSTEP_W-1:0] cnt_ff;
   logic [m3inv_pkg::NUM_W:0]    trial;
   logic [m3inv_pkg::NUM_W-1:0]  shifted;
   logic signed [m3inv_pkg::COF_W-1:0] cof_sel;
   logic signed [m3inv_pkg::NUM_W-1:0] num;

   assign r  = (cmd.idx >= m3inv_pkg::IDX_W'(2 * m3inv_pkg::DIM)) ? m3inv_pkg::IDX_W'(2) :
               (cmd.idx >= m3inv_pkg::IDX_W'(m3inv_pkg::DIM))     ? m3inv_pkg::IDX_W'(1) :
               '0;
   assign c  = cmd.idx - r * m3inv_pkg::IDX_W'(m3inv_pkg::DIM);
   assign r1 = r + m3inv_pkg::IDX_W'(1);
   assign r2 = r + m3inv_pkg::IDX_W'(2);
   assign c1 = c + m3inv_pkg::IDX_W'(1);
   assign c2 = c + m3inv_pkg::IDX_W'(2);

   // Cofactor (j,i) for adjugate slot idx=i*3+j: rows j+1,j+2 cols i+1,i+2.
   // Per cofactor, the two products are registered first, then their difference is stored.
   always_ff @(posedge clock) begin
      if (cmd.load) mat_ff[cmd.idx] <= element;
      if (cmd.cof_step) begin
         if (cph_ff == 2'd0) begin
            pa_ff <= m3inv_pkg::PROD_W'(mat_ff[m3inv_pkg::cyc(c1, r1)]
                     * mat_ff[m3inv_pkg::cyc(c2, r2)]);
            pb_ff <= m3inv_pkg::PROD_W'(mat_ff[m3inv_pkg::cyc(c1, r2)]
                     * mat_ff[m3inv_pkg::cyc(c2, r1)]);
         end else begin
            cof_ff[cmd.idx] <= m3inv_pkg::COF_W'(pa_ff) - m3inv_pkg::COF_W'(pb_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cph_ff <= '0;
      else if (cmd.cof_step) cph_ff <= ~cph_ff[0] ? 2'd1 : 2'd0;
      else cph_ff <= '0;
   end

   // det += m[0][j] * adj[j*3]; one term per step, idx = j
   always_comb begin
      det_in = det_ff + m3inv_pkg::DET_W'(mat_ff[cmd.idx]
               * cof_ff[m3inv_pkg::IDX_W'(cmd.idx * m3inv_pkg::IDX_W'(m3inv_pkg::DIM))]);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) det_ff <= '0;
      else if (cmd.det_step) det_ff <= det_in;
   end

   assign status.det_zero = (det_ff == '0);
   assign status.div_done = ~busy_ff;

   assign cof_sel = cof_ff[cmd.idx];
   assign num     = m3inv_pkg::NUM_W'(cof_sel) <<< 24;
   assign num_mag = num[m3inv_pkg::NUM_W-1] ? m3inv_pkg::NUM_W'(-num) : num;
   assign shifted = {rem_ff[m3inv_pkg::NUM_W-2:0], quo_ff[m3inv_pkg::NUM_W-1]};
   assign trial   = {1'b0, shifted} - {{(m3inv_pkg::NUM_W-m3inv_pkg::DET_W+1){1'b0}}, dmag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
         rem_ff  <= '0;
         quo_ff  <= num_mag;
         dmag_ff <= det_ff[m3inv_pkg::DET_W-1] ? m3inv_pkg::DET_W'(-det_ff) : det_ff;
         neg_ff  <= cof_sel[m3inv_pkg::COF_W-1] ^ det_ff[m3inv_pkg::DET_W-1];
         cnt_ff  <= m3inv_pkg::QSTEP_W'(m3inv_pkg::DIV_STEPS - 1);
      end else if (busy_ff) begin
         if (trial[m3inv_pkg::NUM_W]) begin
            rem_ff <= shifted;
            quo_ff <= {quo_ff[m3inv_pkg::NUM_W-2:0], 1'b0};
         end else begin
            rem_ff <= trial[m3inv_pkg::NUM_W-1:0];
            quo_ff <= {quo_ff[m3inv_pkg::NUM_W-2:0], 1'b1};
         end
         if (cnt_ff == '0) busy_ff <= 1'b0;
         else cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // Magnitude saturation: positive limit 2^31-1, negative limit 2^31.
   always_comb begin
      sat      = 1'b0;
      quotient = '0;
      if (status.det_zero) begin
         quotient = '0;
      end else if (neg_ff) begin
         if (quo_ff > m3inv_pkg::NUM_W'(64'h8000_0000)) begin
            sat = 1'b1;
            quotient = 32'sh8000_0000;
         end else begin
            quotient = m3inv_pkg::OUT_W'(-quo_ff);
         end
      end else begin
         if (quo_ff > m3inv_pkg::NUM_W'(64'h7FFF_FFFF)) begin
            sat = 1'b1;
            quotient = 32'sh7FFF_FFFF;
         end else begin
            quotient = m3inv_pkg::OUT_W'(quo_ff);
         end
      end
   end
endmodule
`default_nettype wire

// ===== design/m3inv_control.sv =====
// ----------------------------------------------------------------------------
// m3inv_control
// Sequencer: load nine entries, form cofactors and determinant, run nine
// divisions (none if singular) and hand each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module m3inv_control (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   out_busy,
   input  wire m3inv_pkg::status_type  status,
   output m3inv_pkg::cmd_type          cmd,
   output logic                        emit,
   output logic                        emit_last
);
   m3inv_pkg::state_type        state_ff, state_in;
   logic [m3inv_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                        ph_ff, ph_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= m3inv_pkg::ST_LOAD;
         idx_ff   <= '0;
         ph_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         ph_ff    <= ph_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      ph_in     = 1'b0;
      cmd       = '0;
      cmd.idx   = idx_ff;
      req_ready = 1'b0;
      emit      = 1'b0;
      emit_last = (idx_ff == m3inv_pkg::IDX_W'(m3inv_pkg::NCELLS - 1));
      unique case (state_ff)
         m3inv_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (idx_ff == m3inv_pkg::IDX_W'(m3inv_pkg::NCELLS - 1)) begin
                  idx_in   = '0;
                  state_in = m3inv_pkg::ST_COF;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         m3inv_pkg::ST_COF: begin
            cmd.cof_step = 1'b1;
            ph_in = ~ph_ff;
            if (ph_ff) begin
               if (idx_ff == m3inv_pkg::IDX_W'(m3inv_pkg::NCELLS - 1)) begin
                  idx_in   = '0;
                  state_in = m3inv_pkg::ST_DET;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         m3inv_pkg::ST_DET: begin
            cmd.det_step = 1'b1;
            if (idx_ff == m3inv_pkg::IDX_W'(m3inv_pkg::DIM - 1)) begin
               idx_in   = '0;
               state_in = m3inv_pkg::ST_DIV_START;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         m3inv_pkg::ST_DIV_START: begin
            if (status.det_zero) begin
               state_in = m3inv_pkg::ST_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in = m3inv_pkg::ST_DIV_WAIT;
            end
         end
         m3inv_pkg::ST_DIV_WAIT: begin
            if (status.div_done) state_in = m3inv_pkg::ST_EMIT;
         end
         m3inv_pkg::ST_EMIT: begin
            if (!out_busy) begin
               emit = 1'b1;
               if (emit_last) begin
                  idx_in   = '0;
                  state_in = m3inv_pkg::ST_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = m3inv_pkg::ST_DIV_START;
               end
            end
         end
         default: state_in = m3inv_pkg::ST_LOAD;
      endcase
   end
endmodule
`default_nettype wire

// ===== design/matrix3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 inverse by adjugate over determinant, Q8.8 in, Q16.16 out.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   element (s16 Q8.8)
//  rsp      out  inverse_entry (s32 Q16.16), singular, saturated, last
//
//  Entries load one per cycle; the ninth starts the cofactor phase and then
//  the determinant phase, then per result the restoring divider (one
//  quotient bit a cycle, 58 bits) plus the output transfer. Singular
//  matrices skip the divider.
//  Reset is synchronous; no input is taken from the ninth entry until the
//  last result is in the output register.
//  A stalled rsp holds its register and stops the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module matrix3x3_inverse (
   input  wire logic clock,
   input  wire logic reset,
   m3inv_stream_if.sink   req,
   m3inv_stream_if.source rsp
);
   m3inv_pkg::cmd_type    cmd;
   m3inv_pkg::status_type status;
   logic signed [m3inv_pkg::OUT_W-1:0] quotient;
   logic sat, emit, emit_last;
   logic valid_ff;
   logic signed [m3inv_pkg::OUT_W-1:0] entry_ff;
   logic sing_ff, sat_ff, last_ff;

   m3inv_control u_ctl (
      .clock, .reset,
      .req_valid (req.valid),
      .req_ready (req.ready),
      .out_busy  (valid_ff && !rsp.ready),
      .status, .cmd, .emit, .emit_last
   );

   m3inv_datapath u_dp (
      .clock, .reset, .cmd,
      .element (req.data.element),
      .status, .quotient, .sat
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (emit) valid_ff <= 1'b1;
      else if (rsp.ready) valid_ff <= 1'b0;
      if (emit) begin
         entry_ff <= quotient;
         sing_ff  <= status.det_zero;
         sat_ff   <= sat;
         last_ff  <= emit_last;
      end
   end

   assign rsp.valid              = valid_ff;
   assign rsp.data.inverse_entry = entry_ff;
   assign rsp.data.singular      = sing_ff;
   assign rsp.data.saturated     = sat_ff;
   assign rsp.data.last          = last_ff;
endmodule
`default_nettype wire

// ===== design/m3inv_checker.sv =====
// ----------------------------------------------------------------------------
// m3inv_checker
// Port-level checks on the inverse block's result stream.
// ----------------------------------------------------------------------------
`default_nettype none
module m3inv_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_entry,
   input wire logic        rsp_singular,
   input wire logic        rsp_saturated,
   input wire logic        rsp_last
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry))
      else $error("rsp payload changed under stall");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_entry == 32'd0 && !rsp_saturated)
      else $error("singular result not zero");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input taken while results pending");
   a_sat_lim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_entry == 32'h7FFF_FFFF || rsp_entry == 32'h8000_0000)
      else $error("saturated value not at limit");
endmodule

bind matrix3x3_inverse m3inv_checker u_chk (
   .clock, .reset,
   .req_valid (req.valid), .req_ready (req.ready),
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
   .rsp_entry (rsp.data.inverse_entry),
   .rsp_singular (rsp.data.singular),
   .rsp_saturated (rsp.data.saturated),
   .rsp_last (rsp.data.last)
);
`default_nettype wire
